// ----- hdl/ssf_pkg.sv -----
package ssf_pkg;

  // Opcodes of an incoming request.
  localparam logic OP_ADD      = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  // Result status codes.
  localparam int unsigned STATUS_BITS = 2;
  localparam logic [STATUS_BITS-1:0] STATUS_ADDED      = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_DISPATCHED = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_EMPTY      = 2'd2;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL       = 2'd3;

  // Width of the pending count field on the result port.
  localparam int unsigned PENDING_BITS = 5;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic load;   // take the incoming request into this cell
    logic shift;  // take the contents of the next cell (removal)
  } cell_ctrl_t;

endpackage

// ----- hdl/shortest_seek_first_scheduler.sv -----
// Channel  | Direction | Handshake                 | Payload
// request  | in        | in_valid_i / in_ready_o   | opcode_i, sector_i, request_tag_i
// result   | out       | out_valid_o / out_ready_i | status_o, out_tag_o, out_sector_o,
//          |           |                           | pending_count_o
//
// An add, a refused add and a dispatch on an empty table give their result in the cycle
// after acceptance. A dispatch with requests pending first registers the distance in
// every cell, and then the best candidate ripples down the chain of cells. One request
// is in work at a time; a new one is taken once the result register is free or being
// emptied. Reset clears the cell valid bits, the head position and the pending count;
// no clearing pass is needed.
module shortest_seek_first_scheduler #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned SECTOR_BITS = 48,
  parameter int unsigned TAG_BITS    = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              opcode_i,
  input  logic [SECTOR_BITS-1:0]            sector_i,
  input  logic [TAG_BITS-1:0]               request_tag_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ssf_pkg::STATUS_BITS-1:0]   status_o,
  output logic [TAG_BITS-1:0]               out_tag_o,
  output logic [SECTOR_BITS-1:0]            out_sector_o,
  output logic [ssf_pkg::PENDING_BITS-1:0]  pending_count_o
);
  import ssf_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_e;

  state_e                   state_q;
  logic [CNT_W-1:0]         count_q;
  logic [CNT_W-1:0]         wait_q;
  logic [SECTOR_BITS-1:0]   head_q;
  logic                     out_valid_q;
  logic [STATUS_BITS-1:0]   status_q;
  logic [TAG_BITS-1:0]      tag_q;
  logic [SECTOR_BITS-1:0]   sector_q;
  logic [CNT_W-1:0]         pend_q;

  logic                     accept;
  logic                     add_go;
  logic                     finish;

  cell_ctrl_t               ctrl   [DEPTH];
  logic                     c_valid  [DEPTH];
  logic [SECTOR_BITS-1:0]   c_sector [DEPTH];
  logic [TAG_BITS-1:0]      c_tag    [DEPTH];
  logic                     b_found  [DEPTH];
  logic [SECTOR_BITS-1:0]   b_dist   [DEPTH];
  logic [IDX_W-1:0]         b_idx    [DEPTH];
  logic [SECTOR_BITS-1:0]   b_sector [DEPTH];
  logic [TAG_BITS-1:0]      b_tag    [DEPTH];

  logic [CNT_W+PENDING_BITS-1:0] pend_ext;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign add_go     = accept && (opcode_i == OP_ADD) && (count_q != CNT_W'(DEPTH));
  assign finish     = (state_q == S_SEARCH) && (wait_q == CNT_W'(DEPTH));

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    logic                   nx_valid;
    logic [SECTOR_BITS-1:0] nx_sector;
    logic [TAG_BITS-1:0]    nx_tag;
    logic                   pv_found;
    logic [SECTOR_BITS-1:0] pv_dist;
    logic [IDX_W-1:0]       pv_idx;
    logic [SECTOR_BITS-1:0] pv_sector;
    logic [TAG_BITS-1:0]    pv_tag;

    if (j == DEPTH - 1) begin : g_last
      assign nx_valid  = 1'b0;
      assign nx_sector = '0;
      assign nx_tag    = '0;
    end else begin : g_mid
      assign nx_valid  = c_valid[j+1];
      assign nx_sector = c_sector[j+1];
      assign nx_tag    = c_tag[j+1];
    end

    if (j == 0) begin : g_first
      assign pv_found  = 1'b0;
      assign pv_dist   = '0;
      assign pv_idx    = '0;
      assign pv_sector = '0;
      assign pv_tag    = '0;
    end else begin : g_rest
      assign pv_found  = b_found[j-1];
      assign pv_dist   = b_dist[j-1];
      assign pv_idx    = b_idx[j-1];
      assign pv_sector = b_sector[j-1];
      assign pv_tag    = b_tag[j-1];
    end

    // New requests go to the end of the occupied prefix; removal closes the gap.
    assign ctrl[j].load  = add_go && (count_q == CNT_W'(j));
    assign ctrl[j].shift = finish && (IDX_W'(j) >= b_idx[DEPTH-1]);

    ssf_cell #(
      .DEPTH       (DEPTH),
      .SECTOR_BITS (SECTOR_BITS),
      .TAG_BITS    (TAG_BITS),
      .CELL_IDX    (j),
      .IDX_W       (IDX_W)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl[j]),
      .load_sector_i (sector_i),
      .load_tag_i    (request_tag_i),
      .next_valid_i  (nx_valid),
      .next_sector_i (nx_sector),
      .next_tag_i    (nx_tag),
      .head_i        (head_q),
      .prev_found_i  (pv_found),
      .prev_dist_i   (pv_dist),
      .prev_idx_i    (pv_idx),
      .prev_sector_i (pv_sector),
      .prev_tag_i    (pv_tag),
      .valid_o       (c_valid[j]),
      .sector_o      (c_sector[j]),
      .tag_o         (c_tag[j]),
      .found_o       (b_found[j]),
      .dist_o        (b_dist[j]),
      .idx_o         (b_idx[j]),
      .best_sector_o (b_sector[j]),
      .best_tag_o    (b_tag[j])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      wait_q      <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
      status_q    <= STATUS_ADDED;
      tag_q       <= '0;
      sector_q    <= '0;
      pend_q      <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            tag_q    <= '0;
            sector_q <= '0;
            if (opcode_i == OP_ADD) begin
              out_valid_q <= 1'b1;
              if (count_q == CNT_W'(DEPTH)) begin
                status_q <= STATUS_FULL;
                pend_q   <= count_q;
              end else begin
                status_q <= STATUS_ADDED;
                count_q  <= count_q + 1'b1;
                pend_q   <= count_q + 1'b1;
              end
            end else if (count_q == '0) begin
              out_valid_q <= 1'b1;
              status_q    <= STATUS_EMPTY;
              pend_q      <= count_q;
            end else begin
              wait_q  <= '0;
              state_q <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          // The output register is free here: acceptance required it.
          if (finish) begin
            out_valid_q <= 1'b1;
            status_q    <= STATUS_DISPATCHED;
            tag_q       <= b_tag[DEPTH-1];
            sector_q    <= b_sector[DEPTH-1];
            head_q      <= b_sector[DEPTH-1];
            count_q     <= count_q - 1'b1;
            pend_q      <= count_q - 1'b1;
            state_q     <= S_IDLE;
          end else begin
            wait_q <= wait_q + 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign pend_ext        = (CNT_W + PENDING_BITS)'(pend_q);
  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign out_tag_o       = tag_q;
  assign out_sector_o    = sector_q;
  assign pending_count_o = pend_ext[PENDING_BITS-1:0];

endmodule

// ----- hdl/ssf_cell.sv -----
module ssf_cell #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned SECTOR_BITS = 48,
  parameter int unsigned TAG_BITS    = 8,
  parameter int unsigned CELL_IDX    = 0,
  parameter int unsigned IDX_W       = $clog2(DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ssf_pkg::cell_ctrl_t    ctrl_i,
  input  logic [SECTOR_BITS-1:0] load_sector_i,
  input  logic [TAG_BITS-1:0]    load_tag_i,
  input  logic                   next_valid_i,
  input  logic [SECTOR_BITS-1:0] next_sector_i,
  input  logic [TAG_BITS-1:0]    next_tag_i,
  input  logic [SECTOR_BITS-1:0] head_i,
  input  logic                   prev_found_i,
  input  logic [SECTOR_BITS-1:0] prev_dist_i,
  input  logic [IDX_W-1:0]       prev_idx_i,
  input  logic [SECTOR_BITS-1:0] prev_sector_i,
  input  logic [TAG_BITS-1:0]    prev_tag_i,
  output logic                   valid_o,
  output logic [SECTOR_BITS-1:0] sector_o,
  output logic [TAG_BITS-1:0]    tag_o,
  output logic                   found_o,
  output logic [SECTOR_BITS-1:0] dist_o,
  output logic [IDX_W-1:0]       idx_o,
  output logic [SECTOR_BITS-1:0] best_sector_o,
  output logic [TAG_BITS-1:0]    best_tag_o
);
  import ssf_pkg::*;

  logic                   valid_q;
  logic [SECTOR_BITS-1:0] sector_q;
  logic [TAG_BITS-1:0]    tag_q;
  logic [SECTOR_BITS-1:0] dist_q, dist_d;
  logic                   found_q;
  logic [SECTOR_BITS-1:0] best_dist_q;
  logic [IDX_W-1:0]       best_idx_q;
  logic [SECTOR_BITS-1:0] best_sector_q;
  logic [TAG_BITS-1:0]    best_tag_q;
  logic                   take_own;

  // Cells are kept in arrival order, so a strict compare leaves ties to the older request.
  assign dist_d   = (sector_q >= head_i) ? (sector_q - head_i) : (head_i - sector_q);
  assign take_own = valid_q && (!prev_found_i || (dist_q < prev_dist_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      found_q <= 1'b0;
    end else begin
      if (ctrl_i.load) begin
        valid_q <= 1'b1;
      end else if (ctrl_i.shift) begin
        valid_q <= next_valid_i;
      end
      found_q <= take_own || prev_found_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      sector_q <= load_sector_i;
      tag_q    <= load_tag_i;
    end else if (ctrl_i.shift) begin
      sector_q <= next_sector_i;
      tag_q    <= next_tag_i;
    end
    dist_q <= dist_d;
    if (take_own) begin
      best_dist_q   <= dist_q;
      best_idx_q    <= IDX_W'(CELL_IDX);
      best_sector_q <= sector_q;
      best_tag_q    <= tag_q;
    end else begin
      best_dist_q   <= prev_dist_i;
      best_idx_q    <= prev_idx_i;
      best_sector_q <= prev_sector_i;
      best_tag_q    <= prev_tag_i;
    end
  end

  assign valid_o       = valid_q;
  assign sector_o      = sector_q;
  assign tag_o         = tag_q;
  assign found_o       = found_q;
  assign dist_o        = best_dist_q;
  assign idx_o         = best_idx_q;
  assign best_sector_o = best_sector_q;
  assign best_tag_o    = best_tag_q;

endmodule

// ----- tb/sv/tb_shortest_seek_first_scheduler.sv -----
`timescale 1ns / 100ps

typedef struct packed {
  logic [ssf_pkg::STATUS_BITS-1:0]  status;
  logic [7:0]                       tag;
  logic [47:0]                      sector;
  logic [ssf_pkg::PENDING_BITS-1:0] count;
} sched_result_t;

class sstf_scoreboard;
  localparam int unsigned SLOTS = 16;
  localparam int unsigned REPORT_LIMIT = 10;

  // Shadow of the pending table and head.
  bit          live [SLOTS];
  logic [47:0] slot_sector [SLOTS];
  logic [7:0]  slot_tag [SLOTS];
  int unsigned slot_age [SLOTS];
  logic [47:0] head;
  int unsigned held;

  sched_result_t due_results[$];
  int unsigned   failures;
  int unsigned   n_added, n_refused, n_dispatched, n_empty, n_ties;

  function new();
    for (int i = 0; i < SLOTS; i++) live[i] = 1'b0;
    head = '0;
    held = 0;
    failures = 0;
    n_added = 0;
    n_refused = 0;
    n_dispatched = 0;
    n_empty = 0;
    n_ties = 0;
  endfunction

  function int unsigned outstanding();
    return due_results.size();
  endfunction

  // Called at the edge that accepts a request; works out its result.
  function void note_request(logic op, logic [47:0] sec, logic [7:0] tag);
    sched_result_t r;
    int            slot;
    int            best;
    logic [47:0]   seek_dist;
    logic [47:0]   best_dist;
    int unsigned   gone_age;
    r = '0;
    best_dist = '0;
    if (op == ssf_pkg::OP_ADD) begin
      slot = -1;
      for (int i = 0; i < SLOTS; i++) if (!live[i] && slot < 0) slot = i;
      if (held >= SLOTS || slot < 0) begin
        r.status = ssf_pkg::STATUS_FULL;
        n_refused++;
      end else begin
        live[slot] = 1'b1;
        slot_sector[slot] = sec;
        slot_tag[slot] = tag;
        slot_age[slot] = held;
        held++;
        r.status = ssf_pkg::STATUS_ADDED;
        n_added++;
      end
    end else begin
      best = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (live[i]) begin
          seek_dist = (head > slot_sector[i]) ? head - slot_sector[i]
                                              : slot_sector[i] - head;
          if (best >= 0 && seek_dist == best_dist) n_ties++;
          if (best < 0 || seek_dist < best_dist ||
              (seek_dist == best_dist && slot_age[i] < slot_age[best])) begin
            best = i;
            best_dist = seek_dist;
          end
        end
      end
      if (best < 0) begin
        r.status = ssf_pkg::STATUS_EMPTY;
        n_empty++;
      end else begin
        gone_age = slot_age[best];
        r.tag = slot_tag[best];
        r.sector = slot_sector[best];
        live[best] = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
          if (live[i] && slot_age[i] > gone_age) slot_age[i]--;
        end
        held--;
        head = slot_sector[best];
        r.status = ssf_pkg::STATUS_DISPATCHED;
        n_dispatched++;
      end
    end
    r.count = held[ssf_pkg::PENDING_BITS-1:0];
    due_results.push_back(r);
  endfunction

  function void check_result(sched_result_t got);
    sched_result_t want;
    if (due_results.size() == 0) begin
      failures++;
      if (failures <= REPORT_LIMIT)
        $display("ERROR: unexpected result status=%0d tag=%0h sector=%0h count=%0d",
                 got.status, got.tag, got.sector, got.count);
      return;
    end
    want = due_results.pop_front();
    if (got !== want) begin
      failures++;
      if (failures <= REPORT_LIMIT) begin
        $display("ERROR: result mismatch: expected status=%0d tag=%0h sector=%0h count=%0d",
                 want.status, want.tag, want.sector, want.count);
        $display("       got status=%0d tag=%0h sector=%0h count=%0d",
                 got.status, got.tag, got.sector, got.count);
      end
    end
  endfunction
endclass

module tb_shortest_seek_first_scheduler;

  localparam int unsigned RANDOM_REQUESTS = 2000;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned DRAIN_CYCLES    = 16 + 2 + 6;
  localparam int unsigned CYCLE_LIMIT     = 800000;
  localparam logic [47:0] SECTOR_TOP      = {48{1'b1}};

  logic                             clk_i;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_ready;
  logic                             opcode;
  logic [47:0]                      sector;
  logic [7:0]                       request_tag;
  logic                             out_valid;
  logic                             out_ready;
  logic [ssf_pkg::STATUS_BITS-1:0]  status;
  logic [7:0]                       out_tag;
  logic [47:0]                      out_sector;
  logic [ssf_pkg::PENDING_BITS-1:0] pending_count;

  sstf_scoreboard sb = new();

  bit          source_gaps_on;
  bit          sink_stalls_on;
  bit          hold_request;
  int unsigned holds_done;
  int unsigned cycle_count;

  shortest_seek_first_scheduler #(
    .DEPTH      (16),
    .SECTOR_BITS(48),
    .TAG_BITS   (8)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .opcode_i       (opcode),
    .sector_i       (sector),
    .request_tag_i  (request_tag),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .out_tag_o      (out_tag),
    .out_sector_o   (out_sector),
    .pending_count_o(pending_count)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{status, out_tag, out_sector, pending_count});
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [47:0] pick_sector();
    int unsigned mode;
    mode = $urandom_range(0, 9);
    if (mode <= 3) return 48'({$urandom, $urandom});
    if (mode <= 6) return 48'($urandom_range(0, 31));
    // Close to the head, so that equal distances on both sides come up.
    if (mode <= 8) begin
      if ($urandom_range(0, 1) != 0) return sb.head + 48'($urandom_range(0, 8));
      return sb.head - 48'($urandom_range(0, 8));
    end
    if ($urandom_range(0, 1) != 0) return SECTOR_TOP - 48'($urandom_range(0, 3));
    return 48'($urandom_range(0, 3));
  endfunction

  // Entered and left at a falling edge.
  task automatic send_request(input logic op, input logic [47:0] sec, input logic [7:0] tag);
    int unsigned gap;
    gap = 0;
    if (source_gaps_on && $urandom_range(0, 99) < 30) gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    sector      <= sec;
    request_tag <= tag;
    do @(posedge clk_i); while (!in_ready);
    sb.note_request(op, sec, tag);
    @(negedge clk_i);
  endtask

  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        holds_done++;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (sink_stalls_on && $urandom_range(0, 99) < 20) stall_left = pick_gap();
      end
    end
  end

  initial begin : request_source
    logic        op;
    int unsigned add_bias;
    in_valid = 1'b0;
    opcode = ssf_pkg::OP_ADD;
    sector = '0;
    request_tag = '0;
    rst_n = 1'b0;
    source_gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    hold_request = 1'b0;
    holds_done = 0;
    cycle_count = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // Directed part: empty table, extreme sectors and tags, ties, a full table.
    send_request(ssf_pkg::OP_DISPATCH, SECTOR_TOP, 8'hff);
    send_request(ssf_pkg::OP_ADD, 48'd0, 8'h00);
    send_request(ssf_pkg::OP_ADD, SECTOR_TOP, 8'hff);
    send_request(ssf_pkg::OP_DISPATCH, 48'd0, 8'h00);
    send_request(ssf_pkg::OP_DISPATCH, 48'd0, 8'h00);
    send_request(ssf_pkg::OP_DISPATCH, 48'd0, 8'h00);
    // The head now sits at the top sector; two requests at the same sector.
    send_request(ssf_pkg::OP_ADD, SECTOR_TOP - 48'd5, 8'h01);
    send_request(ssf_pkg::OP_ADD, SECTOR_TOP - 48'd5, 8'h02);
    send_request(ssf_pkg::OP_DISPATCH, 48'd0, 8'h00);
    // Equal distance on either side of the head: the older one must win.
    send_request(ssf_pkg::OP_ADD, SECTOR_TOP - 48'd2, 8'h03);
    send_request(ssf_pkg::OP_ADD, SECTOR_TOP - 48'd8, 8'h04);
    send_request(ssf_pkg::OP_DISPATCH, 48'd0, 8'h00);
    send_request(ssf_pkg::OP_DISPATCH, 48'd0, 8'h00);
    for (int k = 0; k < 15; k++)
      send_request(ssf_pkg::OP_ADD, 48'({$urandom, $urandom}), 8'(8'h10 + k));
    send_request(ssf_pkg::OP_ADD, 48'h5555_5555_5555, 8'haa);

    add_bias = 50;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: add_bias = 15;
          1: add_bias = 50;
          default: add_bias = 85;
        endcase
        source_gaps_on = ($urandom_range(0, 3) != 0);
        sink_stalls_on = ($urandom_range(0, 3) != 0);
      end
      if (n == 600 || n == 1400) hold_request = 1'b1;
      op = ($urandom_range(0, 99) < add_bias) ? ssf_pkg::OP_ADD : ssf_pkg::OP_DISPATCH;
      send_request(op, pick_sector(), 8'($urandom_range(0, 255)));
    end
    in_valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d adds, %0d refused when full, %0d dispatches, %0d on empty.",
             sb.n_added, sb.n_refused, sb.n_dispatched, sb.n_empty);
    $display("Equal-distance candidates: %0d; long receiver hold-offs: %0d; mismatches: %0d.",
             sb.n_ties, holds_done, sb.failures);
    if (sb.failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
